/* src/rsi_pkg.sv */
// Shared types and constants for the ray / rectangular light intersection block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rsi_pkg;

  localparam int DIST_W     = 24;
  localparam int CFG_DATA_W = 60;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 8;
  localparam int QUOT_BITS  = DIST_W + 1;
  localparam int OVF_SHIFT  = QUOT_BITS - FRAC_BITS;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE = 3'd0,
    REG_EDGE_A = 3'd1,
    REG_EDGE_B = 3'd2,
    REG_NORMAL = 3'd3,
    REG_EPS    = 3'd4
  } cfg_reg_t;

  // Per-item control flags that ride along with the datapath.
  typedef struct packed {
    logic              shadow;
    logic              kill;
    logic              front;
    logic              ovf;
    logic [DIST_W-1:0] cutoff;
  } ctrl_t;

endpackage

/* src/rsi_plane.sv */
// Plane stage: p = origin - centre, then dot(N,p) and dot(N,d) over three stages.
// Depends on rsi_pkg.
`timescale 1ns / 1ps

module rsi_plane
  import rsi_pkg::*;
#(
  parameter int C = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic                 shadow,
  input  logic                 skip,
  input  logic [DIST_W-1:0]    cutoff,
  input  logic signed [C-1:0]  org [3],
  input  logic signed [C-1:0]  dir [3],
  input  logic signed [C-1:0]  cen [3],
  input  logic signed [C-1:0]  nrm [3],
  output logic                 out_vld,
  output ctrl_t                out_ctrl,
  output logic signed [2*C+2:0] num,
  output logic signed [2*C+2:0] den,
  output logic [6*C+2:0]       side
);

  localparam int PW = C + 1;
  localparam int NW = 2 * C + 3;

  logic                 vld1, vld2;
  ctrl_t                ctrl1, ctrl2;
  ctrl_t                out_ctrl_next;
  logic signed [PW-1:0] p1 [3];
  logic signed [PW-1:0] p2 [3];
  logic signed [C-1:0]  d1 [3];
  logic signed [C-1:0]  d2 [3];
  logic signed [2*C:0]  np [3];
  logic signed [2*C-1:0] nd [3];
  logic signed [NW-1:0] sum_np;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  assign sum_np = NW'(np[0]) + NW'(np[1]) + NW'(np[2]);

  // Front face when dot(N,p) is not negative.
  always_comb begin
    out_ctrl_next       = ctrl2;
    out_ctrl_next.front = ~sum_np[NW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl1.shadow <= shadow;
      ctrl1.kill   <= shadow & skip;
      ctrl1.front  <= 1'b0;
      ctrl1.ovf    <= 1'b0;
      ctrl1.cutoff <= cutoff;
      for (int k = 0; k < 3; k++) begin
        p1[k] <= PW'(org[k]) - PW'(cen[k]);
        d1[k] <= dir[k];
      end
      ctrl2 <= ctrl1;
      for (int k = 0; k < 3; k++) begin
        np[k] <= nrm[k] * p1[k];
        nd[k] <= nrm[k] * d1[k];
        p2[k] <= p1[k];
        d2[k] <= d1[k];
      end
      out_ctrl       <= out_ctrl_next;
      num            <= -sum_np;
      den            <= NW'(nd[0]) + NW'(nd[1]) + NW'(nd[2]);
      side           <= {d2[2], d2[1], d2[0], p2[2], p2[1], p2[0]};
    end
  end

endmodule

/* src/rsi_div.sv */
// Pipelined restoring divider: floor(256*|num|/|den|), one quotient bit per stage.
// Depends on rsi_pkg; carries control flags and a sideband word alongside.
`timescale 1ns / 1ps

module rsi_div
  import rsi_pkg::*;
#(
  parameter int C  = 20,
  parameter int SW = 123
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  ctrl_t                 in_ctrl,
  input  logic signed [2*C+2:0] num,
  input  logic signed [2*C+2:0] den,
  input  logic [SW-1:0]         in_side,
  output logic                  out_vld,
  output ctrl_t                 out_ctrl,
  output logic [QUOT_BITS-1:0]  quot,
  output logic [SW-1:0]         out_side
);

  localparam int NW = 2 * C + 3;
  localparam int MW = 2 * C + 2;
  localparam int RW = MW + QUOT_BITS;

  logic                 vld  [QUOT_BITS+1];
  ctrl_t                ctrl [QUOT_BITS+1];
  logic [RW-1:0]        rem  [QUOT_BITS+1];
  logic [MW-1:0]        dv   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q    [QUOT_BITS+1];
  logic [SW-1:0]        side [QUOT_BITS+1];

  logic [MW-1:0] mag_n, mag_d;
  logic          den_zero, neg_t;
  ctrl_t         ctrl_next;

  assign mag_n    = num[NW-1] ? MW'(-num) : MW'(num);
  assign mag_d    = den[NW-1] ? MW'(-den) : MW'(den);
  assign den_zero = (den == '0);
  assign neg_t    = (num != '0) && (num[NW-1] != den[NW-1]);

  always_comb begin
    ctrl_next      = in_ctrl;
    ctrl_next.kill = in_ctrl.kill | den_zero | neg_t;
    ctrl_next.ovf  = (MW+OVF_SHIFT)'(mag_n) >= {mag_d, {OVF_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctrl[0]      <= ctrl_next;
      rem[0]       <= RW'({mag_n, {FRAC_BITS{1'b0}}});
      dv[0]        <= mag_d;
      q[0]         <= '0;
      side[0]      <= in_side;
    end
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_step
    localparam int B = QUOT_BITS - 1 - j;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(dv[j]) << B;
    assign ge  = (rem[j] >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (adv) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctrl[j+1]    <= ctrl[j];
        dv[j+1]      <= dv[j];
        side[j+1]    <= side[j];
        rem[j+1]     <= ge ? rem[j] - dsh : rem[j];
        q[j+1]       <= q[j] | (QUOT_BITS'(ge) << B);
      end
    end
  end

  assign out_vld  = vld[QUOT_BITS];
  assign out_ctrl = ctrl[QUOT_BITS];
  assign quot     = q[QUOT_BITS];
  assign out_side = side[QUOT_BITS];

  // A finished live division leaves a remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[QUOT_BITS] && !ctrl[QUOT_BITS].kill && !ctrl[QUOT_BITS].ovf
      |-> rem[QUOT_BITS] < RW'(dv[QUOT_BITS]))
    else $error("divider remainder not below divisor");

  // A zero divisor must mark the item as a miss.
  a_zero_kill: assert property (@(posedge clk) disable iff (rst)
    vld[1] && dv[1] == '0 |-> ctrl[1].kill)
    else $error("zero denominator not killed");

endmodule

/* src/rsi_edge.sv */
// Back end: clamp t, distance tests, rel = p + d*t, edge tests, hit position.
// Depends on rsi_pkg; output registers form the last stage.
`timescale 1ns / 1ps

module rsi_edge
  import rsi_pkg::*;
#(
  parameter int C  = 20,
  parameter int SW = 123
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  ctrl_t                 in_ctrl,
  input  logic [QUOT_BITS-1:0]  quot,
  input  logic [SW-1:0]         in_side,
  input  logic [DIST_W-1:0]     eps,
  input  logic signed [C-1:0]   cen [3],
  input  logic signed [C-1:0]   ea  [3],
  input  logic signed [C-1:0]   eb  [3],
  input  logic [2*C+1:0]        asq,
  input  logic [2*C+1:0]        bsq,
  output logic                  out_valid,
  output logic                  hit,
  output logic [DIST_W-1:0]     hit_distance,
  output logic signed [C-1:0]   hit_pos_x,
  output logic signed [C-1:0]   hit_pos_y,
  output logic signed [C-1:0]   hit_pos_z
  ,output logic                 front_side
);

  localparam int PW  = C + 1;
  localparam int MLW = C + DIST_W + 1;
  localparam int RLW = C + 18;
  localparam int EPW = 2 * C + 18;
  localparam int DW  = 2 * C + 20;
  localparam int HW  = C + 19;
  localparam logic signed [HW-1:0] PMAX = HW'((2 ** (C - 1)) - 1);
  localparam logic signed [HW-1:0] PMIN = -PMAX - HW'(1);

  logic signed [PW-1:0] p_in [3];
  logic signed [C-1:0]  d_in [3];
  logic [DIST_W-1:0]    t_sat;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign p_in[k] = in_side[k*PW +: PW];
    assign d_in[k] = in_side[3*PW + k*C +: C];
  end

  assign t_sat = (in_ctrl.ovf || quot[QUOT_BITS-1]) ? DIST_MAX : quot[DIST_W-1:0];

  logic                  va, vb, vc;
  logic                  ok_a, ok_b, ok_c;
  logic                  sh_a, sh_b, sh_c, fr_a, fr_b, fr_c;
  logic [DIST_W-1:0]     t_a, t_b, t_c;
  logic signed [PW-1:0]  p_a [3];
  logic signed [MLW-1:0] dt_a [3];
  logic signed [RLW-1:0] rel_b [3];
  logic signed [RLW-1:0] rel_c [3];
  logic signed [EPW-1:0] pa_c [3];
  logic signed [EPW-1:0] pb_c [3];

  logic signed [DW-1:0]  da, db;
  logic [DW-1:0]         da_abs, db_abs;
  logic                  in_box;
  logic signed [HW-1:0]  pos [3];
  logic signed [C-1:0]   pos_sat [3];
  logic                  report;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= in_vld;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  // distance tests and d*t
  always_ff @(posedge clk) begin
    if (adv) begin
      t_a  <= t_sat;
      sh_a <= in_ctrl.shadow;
      fr_a <= in_ctrl.front;
      ok_a <= !in_ctrl.kill && (t_sat >= eps) &&
              (!in_ctrl.shadow || (t_sat < in_ctrl.cutoff));
      for (int k = 0; k < 3; k++) begin
        p_a[k]  <= p_in[k];
        dt_a[k] <= d_in[k] * $signed({1'b0, t_sat});
      end
    end
  end

  // rel = p + floor(d*t / 256)
  always_ff @(posedge clk) begin
    if (adv) begin
      t_b  <= t_a;
      sh_b <= sh_a;
      fr_b <= fr_a;
      ok_b <= ok_a;
      for (int k = 0; k < 3; k++) begin
        rel_b[k] <= RLW'(p_a[k]) + RLW'(dt_a[k] >>> FRAC_BITS);
      end
    end
  end

  // edge products
  always_ff @(posedge clk) begin
    if (adv) begin
      t_c  <= t_b;
      sh_c <= sh_b;
      fr_c <= fr_b;
      ok_c <= ok_b;
      for (int k = 0; k < 3; k++) begin
        rel_c[k] <= rel_b[k];
        pa_c[k]  <= rel_b[k] * ea[k];
        pb_c[k]  <= rel_b[k] * eb[k];
      end
    end
  end

  assign da     = DW'(pa_c[0]) + DW'(pa_c[1]) + DW'(pa_c[2]);
  assign db     = DW'(pb_c[0]) + DW'(pb_c[1]) + DW'(pb_c[2]);
  assign da_abs = da[DW-1] ? DW'(-da) : DW'(da);
  assign db_abs = db[DW-1] ? DW'(-db) : DW'(db);
  assign in_box = (da_abs <= DW'(asq)) && (db_abs <= DW'(bsq));
  assign report = ok_c && in_box && !sh_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos[k] = HW'(rel_c[k]) + HW'(cen[k]);
      if (pos[k] > PMAX) begin
        pos_sat[k] = PMAX[C-1:0];
      end else if (pos[k] < PMIN) begin
        pos_sat[k] = PMIN[C-1:0];
      end else begin
        pos_sat[k] = pos[k][C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit          <= ok_c && in_box;
      hit_distance <= report ? t_c : '0;
      hit_pos_x    <= report ? pos_sat[0] : '0;
      hit_pos_y    <= report ? pos_sat[1] : '0;
      hit_pos_z    <= report ? pos_sat[2] : '0;
      front_side   <= report && fr_c;
    end
  end

endmodule

/* src/ray_square_intersect_top.sv */
// Top level of the ray / rectangular light intersection block.
// Depends on rsi_pkg, rsi_plane, rsi_div and rsi_edge.
`timescale 1ns / 1ps

// Usage:
//   Configuration: write the light through cfg_valid/cfg_ready with cfg_index
//   (0 centre, 1 half-edge A, 2 half-edge B, 3 unit normal, 4 epsilon) and
//   cfg_data; x, y, z sit in consecutive COORD_BITS slices from bit 0.
//   cfg_ready is always high. Write only while no ray is in flight.
//   Input: one ray per transfer on in_valid/in_ready. Output: one result per
//   ray on out_valid/out_ready, in order.
//   From input transfer to out_valid a ray passes three plane stages, a
//   sign/overflow stage plus 25 divider stages (one quotient bit each), and
//   four back-end stages ending in the output register.
//   Throughput is one ray per cycle unless the receiver stalls; the rate is
//   set by the single-bit divider stages, each taking a new item every cycle.
//   When the receiver stalls the whole pipeline holds in place; in_ready drops
//   only while a result waits unclaimed, so nothing is dropped or repeated.
//   Reset clears all valid bits and loads the reset register values (zero
//   vectors, epsilon 1). Squared edge lengths follow a config write through
//   the asq_p and asq registers, well before any ray reaches the edge test.

module ray_square_intersect_top
  import rsi_pkg::*;
#(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic signed [COORD_BITS-1:0] ray_origin_x,
  input  logic signed [COORD_BITS-1:0] ray_origin_y,
  input  logic signed [COORD_BITS-1:0] ray_origin_z,
  input  logic signed [COORD_BITS-1:0] ray_dir_x,
  input  logic signed [COORD_BITS-1:0] ray_dir_y,
  input  logic signed [COORD_BITS-1:0] ray_dir_z,
  input  logic [DIST_W-1:0]            cutoff_distance,
  input  logic                         skip_self,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [DIST_W-1:0]            hit_distance,
  output logic signed [COORD_BITS-1:0] hit_pos_x,
  output logic signed [COORD_BITS-1:0] hit_pos_y,
  output logic signed [COORD_BITS-1:0] hit_pos_z,
  output logic                         front_side
);

  localparam int C  = COORD_BITS;
  localparam int SW = 6 * C + 3;
  localparam int XW = 64;

  logic [CFG_DATA_W-1:0] centre_reg, edge_a_reg, edge_b_reg, normal_reg;
  logic [DIST_W-1:0]     eps_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_reg <= '0;
      edge_a_reg <= '0;
      edge_b_reg <= '0;
      normal_reg <= '0;
      eps_reg    <= DIST_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTRE: centre_reg <= cfg_data;
        REG_EDGE_A: edge_a_reg <= cfg_data;
        REG_EDGE_B: edge_b_reg <= cfg_data;
        REG_NORMAL: normal_reg <= cfg_data;
        REG_EPS:    eps_reg    <= cfg_data[DIST_W-1:0];
        default:    ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Unpack; bits above the register width read as zero.
  logic [XW-1:0]       centre_x, edge_a_x, edge_b_x, normal_x;
  logic signed [C-1:0] cen [3];
  logic signed [C-1:0] ea  [3];
  logic signed [C-1:0] eb  [3];
  logic signed [C-1:0] nrm [3];
  logic signed [C-1:0] org [3];
  logic signed [C-1:0] dir [3];

  assign centre_x = XW'(centre_reg);
  assign edge_a_x = XW'(edge_a_reg);
  assign edge_b_x = XW'(edge_b_reg);
  assign normal_x = XW'(normal_reg);

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign cen[k] = centre_x[k*C +: C];
    assign ea[k]  = edge_a_x[k*C +: C];
    assign eb[k]  = edge_b_x[k*C +: C];
    assign nrm[k] = normal_x[k*C +: C];
  end

  assign org[0] = ray_origin_x;
  assign org[1] = ray_origin_y;
  assign org[2] = ray_origin_z;
  assign dir[0] = ray_dir_x;
  assign dir[1] = ray_dir_y;
  assign dir[2] = ray_dir_z;

  // Squared half-edge lengths, refreshed every cycle from the registers.
  logic signed [2*C-1:0] asq_p [3];
  logic signed [2*C-1:0] bsq_p [3];
  logic [2*C+1:0]        asq, bsq;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      asq_p[k] <= ea[k] * ea[k];
      bsq_p[k] <= eb[k] * eb[k];
    end
    asq <= (2*C+2)'($unsigned(asq_p[0])) + (2*C+2)'($unsigned(asq_p[1]))
         + (2*C+2)'($unsigned(asq_p[2]));
    bsq <= (2*C+2)'($unsigned(bsq_p[0])) + (2*C+2)'($unsigned(bsq_p[1]))
         + (2*C+2)'($unsigned(bsq_p[2]));
  end

  // Advance the whole pipeline unless a finished result is held.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic                  pl_vld, dv_vld;
  ctrl_t                 pl_ctrl, dv_ctrl;
  logic signed [2*C+2:0] num, den;
  logic [SW-1:0]         pl_side, dv_side;
  logic [QUOT_BITS-1:0]  quot;

  rsi_plane #(.C(C)) u_plane (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (in_valid),
    .shadow   (opcode),
    .skip     (skip_self),
    .cutoff   (cutoff_distance),
    .org      (org),
    .dir      (dir),
    .cen      (cen),
    .nrm      (nrm),
    .out_vld  (pl_vld),
    .out_ctrl (pl_ctrl),
    .num      (num),
    .den      (den),
    .side     (pl_side)
  );

  rsi_div #(.C(C), .SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (pl_vld),
    .in_ctrl  (pl_ctrl),
    .num      (num),
    .den      (den),
    .in_side  (pl_side),
    .out_vld  (dv_vld),
    .out_ctrl (dv_ctrl),
    .quot     (quot),
    .out_side (dv_side)
  );

  rsi_edge #(.C(C), .SW(SW)) u_edge (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_vld       (dv_vld),
    .in_ctrl      (dv_ctrl),
    .quot         (quot),
    .in_side      (dv_side),
    .eps          (eps_reg),
    .cen          (cen),
    .ea           (ea),
    .eb           (eb),
    .asq          (asq),
    .bsq          (bsq),
    .out_valid    (out_valid),
    .hit          (hit),
    .hit_distance (hit_distance),
    .hit_pos_x    (hit_pos_x),
    .hit_pos_y    (hit_pos_y),
    .hit_pos_z    (hit_pos_z),
    .front_side   (front_side)
  );

  // A miss carries all-zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_distance == '0 && hit_pos_x == '0 &&
      hit_pos_y == '0 && hit_pos_z == '0 && !front_side)
    else $error("miss with nonzero payload");

endmodule
